/* src/kruskal_mst_weight_assert.svh */
// Assertion macros shared by the union-find engine.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef KRUSKAL_MST_WEIGHT_ASSERT_SVH
`define KRUSKAL_MST_WEIGHT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define KMW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("kmw: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define KMW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("kmw: next-cycle check failed");

`endif

/* src/kmw_pkg.sv */
package kmw_pkg;

	// Field widths of the request and result items.
	localparam int END_W = 10;
	localparam int WEIGHT_W = 32;
	localparam int SUM_W = 42;
	localparam int NCNT_W = 11;

	// Default node capacity of the parent store.
	localparam int NODES_DEF = 1024;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_NODE_COUNT = 1'b0;
	localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_COMP,
		ST_LINK
	} state_t;

	// One result item as it leaves the engine.
	typedef struct packed {
		logic valid;
		logic taken;
		logic [SUM_W-1:0] total;
		logic graph_done;
	} result_t;

endpackage

/* src/kmw_ram.sv */
module kmw_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; a read of the entry
	// being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/kmw_uf.sv */
`include "kruskal_mst_weight_assert.svh"

module kmw_uf #(
	parameter int NODES = kmw_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              in_range,
	input  logic [$clog2(NODES)-1:0]          node_a,
	input  logic [$clog2(NODES)-1:0]          node_b,
	input  logic [kmw_pkg::WEIGHT_W-1:0]      weight,
	input  logic                              final_edge,
	output logic                              busy,
	output kmw_pkg::result_t                  res
);

	localparam int IDX_W = $clog2(NODES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

	kmw_pkg::state_t state_q, state_d;

	// Control registers.
	logic [IDX_W-1:0]            clr_q;
	logic [kmw_pkg::SUM_W-1:0]   sum_q;
	logic                        rvalid_q;

	// Payload registers.
	logic [IDX_W-1:0]            cur_q;
	logic [IDX_W-1:0]            node_q;
	logic [IDX_W-1:0]            b_q;
	logic [IDX_W-1:0]            root_q;
	logic [IDX_W-1:0]            ra_q;
	logic                        side_q;
	logic [kmw_pkg::WEIGHT_W-1:0] w_q;
	logic                        last_q;
	logic                        taken_q;
	logic                        gdone_q;
	logic [kmw_pkg::SUM_W-1:0]   total_q;

	// Parent store access.
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [IDX_W-1:0]            wr_data;
	logic [IDX_W-1:0]            rd_addr;
	logic [IDX_W-1:0]            rdata;

	logic                        link_taken;
	logic [kmw_pkg::SUM_W-1:0]   sum_new;

	kmw_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NODES)
	) u_parent (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Union decision and the sum after this edge.
	assign link_taken = (ra_q != root_q);
	assign sum_new = link_taken ? (sum_q + kmw_pkg::SUM_W'(w_q)) : sum_q;

	assign busy = (state_q != kmw_pkg::ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and parent store controls.
	always_comb begin
		state_d = state_q;
		rd_addr = cur_q;
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_data = root_q;
		case (state_q)
			kmw_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_data = clr_q;
				if (clr_q == LAST_IDX) begin
					state_d = kmw_pkg::ST_IDLE;
				end
			end
			kmw_pkg::ST_IDLE: begin
				rd_addr = node_a;
				if (start) begin
					if (in_range) begin
						state_d = kmw_pkg::ST_FIND;
					end else if (final_edge) begin
						state_d = kmw_pkg::ST_CLEAR;
					end
				end
			end
			kmw_pkg::ST_FIND: begin
				if (rdata == cur_q) begin
					if (node_q == cur_q) begin
						if (side_q) begin
							state_d = kmw_pkg::ST_LINK;
						end else begin
							rd_addr = b_q;
						end
					end else begin
						rd_addr = node_q;
						state_d = kmw_pkg::ST_COMP;
					end
				end else begin
					rd_addr = rdata;
				end
			end
			kmw_pkg::ST_COMP: begin
				// Point the current node straight at the root, then follow its old parent.
				wr_en = 1'b1;
				if (rdata == root_q) begin
					if (side_q) begin
						state_d = kmw_pkg::ST_LINK;
					end else begin
						rd_addr = b_q;
						state_d = kmw_pkg::ST_FIND;
					end
				end else begin
					rd_addr = rdata;
				end
			end
			kmw_pkg::ST_LINK: begin
				wr_en = link_taken;
				wr_addr = ra_q;
				wr_data = root_q;
				state_d = last_q ? kmw_pkg::ST_CLEAR : kmw_pkg::ST_IDLE;
			end
			default: begin
				state_d = kmw_pkg::ST_CLEAR;
			end
		endcase
	end

	// Running sum, clear sweep counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sum_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= 1'b0;
			case (state_q)
				kmw_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				kmw_pkg::ST_IDLE: begin
					if (start && !in_range) begin
						rvalid_q <= 1'b1;
						if (final_edge) begin
							sum_q <= '0;
							clr_q <= '0;
						end
					end
				end
				kmw_pkg::ST_LINK: begin
					rvalid_q <= 1'b1;
					sum_q <= last_q ? '0 : sum_new;
					clr_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Walk pointers, latched request fields and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			kmw_pkg::ST_IDLE: begin
				if (start) begin
					cur_q <= node_a;
					node_q <= node_a;
					b_q <= node_b;
					w_q <= weight;
					last_q <= final_edge;
					side_q <= 1'b0;
					taken_q <= 1'b0;
					total_q <= sum_q;
					gdone_q <= final_edge;
				end
			end
			kmw_pkg::ST_FIND: begin
				if (rdata == cur_q) begin
					root_q <= cur_q;
					if (node_q != cur_q) begin
						cur_q <= node_q;
					end else if (!side_q) begin
						// Second endpoint begins once the first root is known.
						ra_q <= cur_q;
						side_q <= 1'b1;
						cur_q <= b_q;
						node_q <= b_q;
					end
				end else begin
					cur_q <= rdata;
				end
			end
			kmw_pkg::ST_COMP: begin
				if ((rdata == root_q) && !side_q) begin
					// Path of the first endpoint is rewritten; start the second one.
					ra_q <= root_q;
					side_q <= 1'b1;
					cur_q <= b_q;
					node_q <= b_q;
				end else begin
					cur_q <= rdata;
				end
			end
			kmw_pkg::ST_LINK: begin
				taken_q <= link_taken;
				total_q <= sum_new;
				gdone_q <= last_q;
			end
			default: begin
			end
		endcase
	end

	assign res.valid = rvalid_q;
	assign res.taken = taken_q;
	assign res.total = total_q;
	assign res.graph_done = gdone_q;

	// An accepted request either starts a walk or answers at once.
	`KMW_ASSERT_NXT(a_accept_progress, clk, arst_n, start && (state_q == kmw_pkg::ST_IDLE), busy || rvalid_q)
	// The parent store is written only by compression, linking or the clear sweep.
	`KMW_ASSERT_NOW(a_write_states, clk, arst_n, wr_en, (state_q == kmw_pkg::ST_CLEAR) || (state_q == kmw_pkg::ST_COMP) || (state_q == kmw_pkg::ST_LINK))
	// The result that closes a graph is always followed by a store clear.
	`KMW_ASSERT_NOW(a_final_clears, clk, arst_n, rvalid_q && gdone_q, state_q == kmw_pkg::ST_CLEAR)

endmodule

/* src/kruskal_mst_weight.sv */
// Streaming Kruskal spanning-tree weight with a union-find parent store.
// Edges are issued in nondecreasing weight order: drive end_a, end_b, weight and
// final_edge with start high; the request is accepted when busy is low.
// Each request yields one result on taken, total_weight and graph_done, marked
// by result_valid for exactly one cycle; the receiver cannot stall it.
// An edge with an endpoint at or above min(node_count, NODES) is answered in the
// cycle after acceptance with taken low and the sum unchanged.
// An in-range edge walks up from end_a to its root and rewrites that path by
// path compression, does the same from end_b, then links the two roots; each
// step is one read of the single parent store, whose registered read port sets
// the pace. Compression keeps paths short. After reset, and after the result of
// an edge marked final_edge, the store is swept back to self-parents entry by
// entry with busy high, and the sum is cleared. node_count is to be written over
// the APB port only while the block is idle; the block does not enforce this.
module kruskal_mst_weight #(
	parameter int NODES = kmw_pkg::NODES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kmw_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [kmw_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [kmw_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [kmw_pkg::END_W-1:0]           end_a,
	input  logic [kmw_pkg::END_W-1:0]           end_b,
	input  logic [kmw_pkg::WEIGHT_W-1:0]        weight,
	input  logic                                final_edge,
	output logic                                result_valid,
	output logic                                taken,
	output logic [kmw_pkg::SUM_W-1:0]           total_weight,
	output logic                                graph_done
);

	localparam int IDX_W = $clog2(NODES);
	localparam int LIM_W = $clog2(NODES + 1);
	localparam int CMP_W = (LIM_W > kmw_pkg::NCNT_W) ? LIM_W : kmw_pkg::NCNT_W;

	logic [kmw_pkg::NCNT_W-1:0] node_count_q;
	logic [CMP_W-1:0]           count_ext;
	logic [CMP_W-1:0]           limit;
	logic                       in_range;
	kmw_pkg::result_t           res;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= kmw_pkg::NODE_COUNT_RST;
		end else if (psel && penable && pwrite && (paddr[2:2] == kmw_pkg::REG_NODE_COUNT)) begin
			node_count_q <= pwdata[kmw_pkg::NCNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == kmw_pkg::REG_NODE_COUNT)
		? kmw_pkg::APB_DATA_W'(node_count_q) : '0;

	// Nodes in use are capped at the store depth.
	assign count_ext = CMP_W'(node_count_q);
	assign limit = (count_ext > CMP_W'(NODES)) ? CMP_W'(NODES) : count_ext;
	assign in_range = (CMP_W'(end_a) < limit) && (CMP_W'(end_b) < limit);

	kmw_uf #(
		.NODES (NODES)
	) u_uf (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.in_range   (in_range),
		.node_a     (IDX_W'(end_a)),
		.node_b     (IDX_W'(end_b)),
		.weight     (weight),
		.final_edge (final_edge),
		.busy       (busy),
		.res        (res)
	);

	assign result_valid = res.valid;
	assign taken = res.taken;
	assign total_weight = res.total;
	assign graph_done = res.graph_done;

endmodule

/* dv/tb_kruskal_mst_weight.sv */
`timescale 1ns / 100ps

module tb_kruskal_mst_weight;

	import kmw_pkg::*;

	localparam int NODE_CAP = NODES_DEF;
	localparam int ITEM_TARGET = 1400;
	localparam int RANDOM_TARGET = 1250;
	// Long enough to cover a full clearing sweep of the parent store.
	localparam int END_SETTLE = 2 * NODE_CAP + 64;
	localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = APB_ADDR_W'(4 * REG_NODE_COUNT);

	// One expected result of an edge request.
	typedef struct {
		logic taken;
		logic [SUM_W-1:0] total;
		logic done;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [END_W-1:0] end_a;
	logic [END_W-1:0] end_b;
	logic [WEIGHT_W-1:0] weight;
	logic final_edge;
	logic result_valid;
	logic taken;
	logic [SUM_W-1:0] total_weight;
	logic graph_done;

	// Shadow copy of the union-find forest and the configured node count.
	logic [END_W-1:0] forest_parent [NODE_CAP];
	logic [SUM_W-1:0] tree_sum;
	logic [NCNT_W-1:0] node_count_cfg;

	edge_result_t results_due [$];
	int mismatches = 0;
	int edges_sent = 0;
	bit gaps_on = 1'b0;
	bit calm = 1'b0;

	kruskal_mst_weight u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.end_a(end_a),
		.end_b(end_b),
		.weight(weight),
		.final_edge(final_edge),
		.result_valid(result_valid),
		.taken(taken),
		.total_weight(total_weight),
		.graph_done(graph_done)
	);

	always #6 clk = ~clk;

	// Every node becomes its own root and the tree sum starts over.
	function automatic void forest_clear();
		for (int i = 0; i < NODE_CAP; i++) begin
			forest_parent[i] = END_W'(i);
		end
		tree_sum = '0;
	endfunction

	// Root lookup, then every node on the walked path is pointed at the root.
	function automatic logic [END_W-1:0] forest_root(input logic [END_W-1:0] node);
		logic [END_W-1:0] root;
		logic [END_W-1:0] cur;
		logic [END_W-1:0] nxt;
		int steps;
		root = node;
		steps = 0;
		while (forest_parent[root] != root && steps < NODE_CAP) begin
			root = forest_parent[root];
			steps++;
		end
		cur = node;
		steps = 0;
		while (cur != root && steps < NODE_CAP) begin
			nxt = forest_parent[cur];
			forest_parent[cur] = root;
			cur = nxt;
			steps++;
		end
		return root;
	endfunction

	// Nodes in use: the configured count, capped at the store size.
	function automatic int node_limit();
		return (node_count_cfg > NODE_CAP) ? NODE_CAP : int'(node_count_cfg);
	endfunction

	// Kruskal step for one edge: union of the two trees when they differ.
	function automatic edge_result_t mst_predict(input logic [END_W-1:0] a,
			input logic [END_W-1:0] b, input logic [WEIGHT_W-1:0] w, input logic last);
		edge_result_t res;
		logic [END_W-1:0] ra;
		logic [END_W-1:0] rb;
		int lim;
		lim = node_limit();
		res.taken = 1'b0;
		if (int'(a) < lim && int'(b) < lim) begin
			ra = forest_root(a);
			rb = forest_root(b);
			if (ra != rb) begin
				forest_parent[ra] = rb;
				tree_sum = tree_sum + SUM_W'(w);
				res.taken = 1'b1;
			end
		end
		res.total = tree_sum;
		res.done = last;
		if (last) begin
			forest_clear();
		end
		return res;
	endfunction

	// Each strobed result is matched against the oldest expected one.
	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && result_valid) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: taken=%0b total_weight=%0d graph_done=%0b",
					taken, total_weight, graph_done);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (taken !== want.taken) begin
					$error("taken: expected %0b, actual %0b", want.taken, taken);
					mismatches++;
				end
				if (total_weight !== want.total) begin
					$error("total_weight: expected %0d, actual %0d", want.total, total_weight);
					mismatches++;
				end
				if (graph_done !== want.done) begin
					$error("graph_done: expected %0b, actual %0b", want.done, graph_done);
					mismatches++;
				end
			end
		end
	end

	// Lower start and hold it low for a number of cycles.
	task automatic rest(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Present one edge request and wait until the block takes it.
	task automatic send_edge(input logic [END_W-1:0] a, input logic [END_W-1:0] b,
			input logic [WEIGHT_W-1:0] w, input logic last);
		start <= 1'b1;
		end_a <= a;
		end_b <= b;
		weight <= w;
		final_edge <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		results_due.push_back(mst_predict(a, b, w, last));
		edges_sent++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			rest($urandom_range(1, 18));
		end
	endtask

	// Wait until every result is back and the block is idle again.
	task automatic drain_edges();
		start <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// APB read of node_count, compared with the shadow value.
	task automatic check_node_count_readback();
		logic [APB_DATA_W-1:0] want;
		want = APB_DATA_W'(node_count_cfg);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= NODE_COUNT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata: expected %0d, actual %0d", want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB write of node_count; the upper data bits carry random noise.
	task automatic set_node_count(input logic [NCNT_W-1:0] value);
		logic [APB_DATA_W-1:0] data;
		data = $urandom;
		data[NCNT_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= NODE_COUNT_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		node_count_cfg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		check_node_count_readback();
	endtask

	// Node counts biased toward small graphs, with the extremes mixed in.
	function automatic logic [NCNT_W-1:0] pick_node_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return NCNT_W'(1);
			2: return NCNT_W'(2);
			3, 4, 5: return NCNT_W'($urandom_range(3, 24));
			6: return NCNT_W'($urandom_range(25, 200));
			7: return NCNT_W'(NODE_CAP);
			8: return NCNT_W'($urandom_range(NODE_CAP + 1, 2047));
			default: return NCNT_W'($urandom_range(201, NODE_CAP - 1));
		endcase
	endfunction

	// One graph: random edges in mostly nondecreasing weight order, sometimes led by a chain.
	task automatic run_graph();
		int lim;
		int n_edges;
		int chain_len;
		int cfg_at;
		logic [END_W-1:0] a;
		logic [END_W-1:0] b;
		logic [END_W-1:0] tmp;
		logic [WEIGHT_W-1:0] wt;
		logic [WEIGHT_W:0] sum_next;
		logic closes;
		if (!calm && $urandom_range(0, 3) == 0) begin
			drain_edges();
			set_node_count(pick_node_count());
		end
		lim = node_limit();
		gaps_on = !calm && ($urandom_range(0, 2) != 0);
		if (lim <= 1) begin
			n_edges = $urandom_range(1, 4);
		end else begin
			n_edges = $urandom_range(1, (2 * lim + 4 < 80) ? 2 * lim + 4 : 80);
		end
		chain_len = 0;
		if (lim >= 4 && $urandom_range(0, 3) == 0) begin
			chain_len = $urandom_range(3, 40);
			if (chain_len > lim - 1) begin
				chain_len = lim - 1;
			end
		end
		closes = ($urandom_range(0, 9) != 0);
		cfg_at = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(0, n_edges - 1) : -1;
		wt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 500);
		for (int i = 0; i < n_edges; i++) begin
			// A register change in the middle of a graph keeps the forest.
			if (i == cfg_at) begin
				drain_edges();
				set_node_count(pick_node_count());
				lim = node_limit();
			end
			if (i > 0) begin
				if ($urandom_range(0, 24) == 0) begin
					wt = $urandom;
				end else begin
					sum_next = wt + $urandom_range(0, 4);
					wt = sum_next[WEIGHT_W] ? '1 : sum_next[WEIGHT_W-1:0];
				end
			end
			if (i < chain_len) begin
				a = END_W'(i);
				b = END_W'(i + 1);
				if ($urandom_range(0, 1) == 1) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end else if (lim == 0) begin
				a = END_W'($urandom_range(0, NODE_CAP - 1));
				b = END_W'($urandom_range(0, NODE_CAP - 1));
			end else begin
				a = END_W'($urandom_range(0, lim - 1));
				b = END_W'($urandom_range(0, lim - 1));
				if ($urandom_range(0, 14) == 0) begin
					b = a;
				end
				if (lim < NODE_CAP && $urandom_range(0, 11) == 0) begin
					if ($urandom_range(0, 1) == 0) begin
						a = END_W'($urandom_range(lim, NODE_CAP - 1));
					end else begin
						b = END_W'($urandom_range(lim, NODE_CAP - 1));
					end
				end
			end
			send_edge(a, b, wt, closes && (i == n_edges - 1));
		end
	endtask

	// Reset value, extremes and readback of the node_count register.
	task automatic test_register_access();
		check_node_count_readback();
		set_node_count(11'd2047);
		set_node_count('0);
		set_node_count(NCNT_W'(NODE_CAP));
	endtask

	// Hand-picked edges: extremes of every field and each special case.
	task automatic test_directed_edges();
		gaps_on = 1'b1;
		// Full store: widest endpoints and a zero weight.
		send_edge(10'd0, 10'd1023, 32'd0, 1'b0);
		send_edge(10'd1023, 10'd0, 32'd5, 1'b0);
		// Self loop never joins anything.
		send_edge(10'd7, 10'd7, 32'd5, 1'b0);
		// Build a chain, then walk it from the far end to force compression.
		send_edge(10'd1, 10'd2, 32'd6, 1'b0);
		send_edge(10'd2, 10'd3, 32'd6, 1'b0);
		send_edge(10'd3, 10'd4, 32'd7, 1'b0);
		send_edge(10'd4, 10'd5, 32'd8, 1'b0);
		send_edge(10'd1, 10'd9, 32'd9, 1'b0);
		send_edge(10'd682, 10'd341, 32'hFFFF_FFFF, 1'b0);
		// A weight out of order is still processed as it comes.
		send_edge(10'd100, 10'd200, 32'd3, 1'b0);
		send_edge(10'd5, 10'd1023, 32'hFFFF_FFFF, 1'b1);

		// Small graph with endpoints beyond the node count.
		drain_edges();
		set_node_count(11'd4);
		send_edge(10'd4, 10'd0, 32'd1, 1'b0);
		send_edge(10'd0, 10'd1023, 32'd1, 1'b0);
		send_edge(10'd3, 10'd2, 32'd2, 1'b0);
		send_edge(10'd0, 10'd3, 32'd3, 1'b1);

		// A zero node count leaves every endpoint out of range.
		drain_edges();
		set_node_count('0);
		send_edge(10'd0, 10'd0, 32'd7, 1'b1);

		// A count above the store size acts as the store size.
		drain_edges();
		set_node_count(11'd2047);
		send_edge(10'd1023, 10'd512, 32'd9, 1'b0);
		send_edge(10'd512, 10'd1023, 32'd10, 1'b1);

		drain_edges();
		set_node_count(11'd1);
		send_edge(10'd0, 10'd0, 32'd1, 1'b0);
		send_edge(10'd0, 10'd1, 32'd2, 1'b1);

		drain_edges();
		set_node_count(NCNT_W'(NODE_CAP + 1));
		send_edge(10'd1023, 10'd0, 32'd4, 1'b1);
	endtask

	// Random graphs with random sizes, register changes and sender gaps.
	task automatic test_random_graphs();
		while (edges_sent < RANDOM_TARGET) begin
			run_graph();
		end
	endtask

	// Closing stretch: back-to-back requests with no gaps on small graphs.
	task automatic test_steady_stream();
		drain_edges();
		set_node_count(NCNT_W'($urandom_range(3, 24)));
		calm = 1'b1;
		while (edges_sent < ITEM_TARGET) begin
			run_graph();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		end_a = '0;
		end_b = '0;
		weight = '0;
		final_edge = 1'b0;
		forest_clear();
		node_count_cfg = NODE_COUNT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// The store is swept to self-parents after reset.
		@(posedge clk);
		while (busy) @(posedge clk);

		test_register_access();
		test_directed_edges();
		test_random_graphs();
		test_steady_stream();

		drain_edges();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
